// ----- rtl/dsu_pkg.sv -----
// Shared types and constants for the disjoint-set union engine.
`timescale 1ns / 1ps

package dsu_pkg;

  // Fixed field widths of the stream words
  localparam int CMD_W      = 2;
  localparam int IN_IDX_W   = 10;
  localparam int OUT_IDX_W  = 10;
  localparam int OUT_SIZE_W = 11;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 32;

  // Index reduction: a reciprocal multiply for the quotient, then a multiply-subtract
  localparam int MOD_STEPS  = 2;
  localparam int MOD_STEP_W = 1;
  localparam int MOD_SHIFT  = 20;

  typedef enum logic [CMD_W-1:0] {
    CMD_MERGE = 2'd0,
    CMD_SAME  = 2'd1,
    CMD_SIZE  = 2'd2,
    CMD_ALIAS = 2'd3
  } cmd_e;

  typedef enum logic [8:0] {
    S_CLEAR     = 9'b000000001,
    S_IDLE      = 9'b000000010,
    S_MOD       = 9'b000000100,
    S_FIND      = 9'b000001000,
    S_WALK      = 9'b000010000,
    S_CMP       = 9'b000100000,
    S_MRG_BIG   = 9'b001000000,
    S_MRG_SMALL = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_e;

endpackage

// ----- rtl/dsu_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module dsu_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/disjoint_set_union_engine.sv -----
// Disjoint-set union engine: union by size with path compression over a RAM table.
//
//   channel  dir  handshake                      word contents (lsb first)
//   s_axis   in   s_axis_tvalid / s_axis_tready  cmd[1:0] x_index[11:2] y_index[21:12]
//   m_axis   out  m_axis_tvalid / m_axis_tready  root_x, root_y, connected, comp_size
//
// One command at a time. Each root search costs one RAM read per hop, then one
// RAM write per path node for the rewrite. A size command searches the root of x
// only, a merge or same command those of x and y; a merge that joins two components
// adds two table writes, and index reduction runs first when NODE_COUNT is not a
// power of two below 1024.
// After reset a clearing pass writes all NODE_COUNT entries; no word is taken then.
// A finished result sits in the output register; the next word is taken while it waits.
`timescale 1ns / 1ps

module disjoint_set_union_engine #(
  parameter int NODE_COUNT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // cmd[1:0], x_index[11:2], y_index[21:12], zero pad [23:22]
  input  logic [dsu_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // root_x[9:0], root_y[19:10], connected[20], comp_size[31:21]
  output logic [dsu_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int SZ_W  = IDX_W + 1;
  localparam int EW    = IDX_W + 2;
  localparam int VW    = (IDX_W > dsu_pkg::IN_IDX_W) ? IDX_W : dsu_pkg::IN_IDX_W;
  localparam int MW    = VW + dsu_pkg::MOD_SHIFT;
  localparam int PW    = 2 * VW;
  localparam int OW    = (SZ_W > dsu_pkg::OUT_SIZE_W) ? SZ_W : dsu_pkg::OUT_SIZE_W;
  localparam int MOD_RECIP = ((1 << dsu_pkg::MOD_SHIFT) + NODE_COUNT - 1) / NODE_COUNT;
  localparam bit NEED_MOD = (NODE_COUNT < (1 << dsu_pkg::IN_IDX_W)) &&
                            ((NODE_COUNT & (NODE_COUNT - 1)) != 0);

  // Quotient by NODE_COUNT; exact for indexes below 1024 with this shift
  function automatic logic [VW-1:0] mod_quot(logic [VW-1:0] v);
    logic [MW-1:0] p;
    p = MW'(v) * MW'(MOD_RECIP);
    return VW'(p >> dsu_pkg::MOD_SHIFT);
  endfunction

  function automatic logic [VW-1:0] mod_rem(logic [VW-1:0] v, logic [VW-1:0] q);
    logic [PW-1:0] p;
    p = PW'(q) * PW'(NODE_COUNT);
    return VW'(PW'(v) - p);
  endfunction

  dsu_pkg::state_e state_q, state_d;
  dsu_pkg::cmd_e   cmd_q, cmd_d;

  logic [IDX_W-1:0]               clr_q, clr_d;
  logic [dsu_pkg::MOD_STEP_W-1:0] step_q, step_d;
  logic                           phase_q, phase_d;
  logic [VW-1:0]                  x_q, x_d, y_q, y_d;
  logic [VW-1:0]                  qx_q, qx_d, qy_q, qy_d;
  logic [IDX_W-1:0]               cur_q, cur_d;
  logic [IDX_W-1:0]               rx_q, rx_d, ry_q, ry_d;
  logic [SZ_W-1:0]                sx_q, sx_d, sy_q, sy_d;
  logic                           out_valid_q, out_valid_d;
  logic [dsu_pkg::M_TDATA_W-1:0]  out_data_q, out_data_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_wa, ram_ra;
  logic [EW-1:0]    ram_wd, ram_rd;

  logic             rd_root;
  logic [SZ_W-1:0]  rd_size;
  logic [IDX_W-1:0] rd_parent;
  logic [IDX_W-1:0] start_idx, cur_root, big_idx, small_idx;
  logic [SZ_W-1:0]  sum_size;
  logic             find_done, in_accept, load_out, is_size;
  logic [VW-1:0]    root_x_ext, root_y_ext;
  logic [OW-1:0]    size_ext;

  dsu_ram #(
    .WIDTH(EW),
    .DEPTH(NODE_COUNT)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_wa),
    .wdata_i(ram_wd),
    .raddr_i(ram_ra),
    .rdata_o(ram_rd)
  );

  // Entry: root flag on top; below it the size for a root, else the parent index
  assign rd_root   = ram_rd[EW-1];
  assign rd_size   = ram_rd[SZ_W-1:0];
  assign rd_parent = ram_rd[IDX_W-1:0];

  assign start_idx = phase_q ? y_q[IDX_W-1:0] : x_q[IDX_W-1:0];
  assign cur_root  = phase_q ? ry_q : rx_q;
  assign big_idx   = (sx_q < sy_q) ? ry_q : rx_q;
  assign small_idx = (sx_q < sy_q) ? rx_q : ry_q;
  assign sum_size  = sx_q + sy_q;

  assign s_axis_tready = (state_q == dsu_pkg::S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign load_out      = (state_q == dsu_pkg::S_DONE) && (!out_valid_q || m_axis_tready);
  assign is_size       = (cmd_q == dsu_pkg::CMD_SIZE);

  assign root_x_ext = VW'(rx_q);
  assign root_y_ext = VW'(ry_q);
  assign size_ext   = OW'(sx_q);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    clr_d     = clr_q;
    step_d    = step_q;
    phase_d   = phase_q;
    x_d       = x_q;
    y_d       = y_q;
    qx_d      = qx_q;
    qy_d      = qy_q;
    cur_d     = cur_q;
    rx_d      = rx_q;
    ry_d      = ry_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    ram_we    = 1'b0;
    ram_wa    = cur_q;
    ram_wd    = '0;
    ram_ra    = cur_q;
    find_done = 1'b0;

    unique case (state_q)
      dsu_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        ram_wa = clr_q;
        ram_wd = {1'b1, SZ_W'(1)};
        clr_d  = clr_q + 1'b1;
        if (clr_q == IDX_W'(NODE_COUNT - 1)) begin
          state_d = dsu_pkg::S_IDLE;
        end
      end
      dsu_pkg::S_IDLE: begin
        if (in_accept) begin
          cmd_d   = dsu_pkg::cmd_e'(s_axis_tdata[dsu_pkg::CMD_W-1:0]);
          x_d     = VW'(s_axis_tdata[dsu_pkg::CMD_W +: dsu_pkg::IN_IDX_W]);
          y_d     = VW'(s_axis_tdata[dsu_pkg::CMD_W + dsu_pkg::IN_IDX_W +: dsu_pkg::IN_IDX_W]);
          phase_d = 1'b0;
          step_d  = dsu_pkg::MOD_STEP_W'(dsu_pkg::MOD_STEPS - 1);
          state_d = NEED_MOD ? dsu_pkg::S_MOD : dsu_pkg::S_FIND;
        end
      end
      dsu_pkg::S_MOD: begin
        // quotients first, remainders on the following cycle
        if (step_q != '0) begin
          qx_d = mod_quot(x_q);
          qy_d = mod_quot(y_q);
        end else begin
          x_d     = mod_rem(x_q, qx_q);
          y_d     = mod_rem(y_q, qy_q);
          state_d = dsu_pkg::S_FIND;
        end
        step_d = step_q - 1'b1;
      end
      dsu_pkg::S_FIND: begin
        ram_ra  = start_idx;
        cur_d   = start_idx;
        state_d = dsu_pkg::S_WALK;
      end
      dsu_pkg::S_WALK: begin
        if (rd_root) begin
          if (phase_q) begin
            ry_d = cur_q;
            sy_d = rd_size;
          end else begin
            rx_d = cur_q;
            sx_d = rd_size;
          end
          if (cur_q == start_idx) begin
            find_done = 1'b1;
          end else begin
            // rewrite the path from its start
            ram_ra  = start_idx;
            cur_d   = start_idx;
            state_d = dsu_pkg::S_CMP;
          end
        end else begin
          ram_ra = rd_parent;
          cur_d  = rd_parent;
        end
      end
      dsu_pkg::S_CMP: begin
        ram_we = 1'b1;
        ram_wa = cur_q;
        ram_wd = EW'(cur_root);
        if (rd_parent == cur_root) begin
          find_done = 1'b1;
        end else begin
          ram_ra = rd_parent;
          cur_d  = rd_parent;
        end
      end
      dsu_pkg::S_MRG_BIG: begin
        ram_we  = 1'b1;
        ram_wa  = big_idx;
        ram_wd  = {1'b1, sum_size};
        rx_d    = big_idx;
        ry_d    = small_idx;
        sx_d    = sum_size;
        state_d = dsu_pkg::S_MRG_SMALL;
      end
      dsu_pkg::S_MRG_SMALL: begin
        ram_we  = 1'b1;
        ram_wa  = ry_q;
        ram_wd  = EW'(rx_q);
        ry_d    = rx_q;
        state_d = dsu_pkg::S_DONE;
      end
      dsu_pkg::S_DONE: begin
        if (load_out) begin
          state_d = dsu_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dsu_pkg::S_IDLE;
      end
    endcase

    if (find_done) begin
      if (!phase_q) begin
        if (is_size) begin
          state_d = dsu_pkg::S_DONE;
        end else begin
          phase_d = 1'b1;
          state_d = dsu_pkg::S_FIND;
        end
      end else if (cmd_q == dsu_pkg::CMD_MERGE && rx_d != ry_d) begin
        state_d = dsu_pkg::S_MRG_BIG;
      end else begin
        state_d = dsu_pkg::S_DONE;
      end
    end
  end

  always_comb begin
    out_data_d = out_data_q;
    if (load_out) begin
      out_data_d[9:0]   = root_x_ext[dsu_pkg::OUT_IDX_W-1:0];
      out_data_d[19:10] = is_size ? '0 : root_y_ext[dsu_pkg::OUT_IDX_W-1:0];
      out_data_d[20]    = is_size ? 1'b0 : (rx_q == ry_q);
      out_data_d[31:21] = size_ext[dsu_pkg::OUT_SIZE_W-1:0];
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsu_pkg::S_CLEAR;
      clr_q       <= '0;
      step_q      <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      step_q      <= step_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    x_q        <= x_d;
    y_q        <= y_d;
    qx_q       <= qx_d;
    qy_q       <= qy_d;
    cur_q      <= cur_d;
    rx_q       <= rx_d;
    ry_q       <= ry_d;
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A merge only ever joins two distinct roots
  a_merge_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dsu_pkg::S_MRG_BIG) |-> (rx_q != ry_q))
    else $error("merge started on a single root");

  // Nodes on a rewritten path are never roots
  a_path_not_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dsu_pkg::S_CMP) |-> !rd_root)
    else $error("path rewrite reached a root entry");

  // A new result word only appears after the done state
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == dsu_pkg::S_DONE))
    else $error("result word without finished command");

  // The clearing pass only ends into idle
  a_clear_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dsu_pkg::S_CLEAR) |=>
      (state_q == dsu_pkg::S_CLEAR || state_q == dsu_pkg::S_IDLE))
    else $error("clearing pass left to a busy state");

endmodule
